@@ rtl/assert_macros.svh @@
// Assertion macros of the frame pacer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge once reset is released.
`define FPSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fpsd assertion failed");
// Check that a condition never holds on a rising edge outside reset.
`define FPSD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("fpsd forbidden condition seen");
`else
`define FPSD_ASSERT(lbl, clk, rstn, prop)
`define FPSD_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ rtl/fpsd_pkg.sv @@
// Shared types, widths and codes of the frame pacer.
package fpsd_pkg;

  localparam int SMOOTH_DEPTH = 16;
  localparam int TIME_W       = 48;
  localparam int DELTA_W      = 24;
  localparam int COUNT_W      = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int RING_AW      = $clog2(SMOOTH_DEPTH);
  localparam int SUM_W        = DELTA_W + $clog2(SMOOTH_DEPTH);
  localparam int CNT_W        = $clog2(SMOOTH_DEPTH + 1);
  localparam int DCNT_W       = $clog2(SUM_W + 1);

  localparam logic [DELTA_W-1:0] MAX_DELTA_RST     = DELTA_W'(100000);
  localparam logic [DELTA_W-1:0] DEFAULT_DELTA_RST = DELTA_W'(16667);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_EN    = 3'd0,
    CFG_SMOOTH_EN   = 3'd1,
    CFG_TARGET      = 3'd2,
    CFG_MAX_DELTA   = 3'd3,
    CFG_DEFAULT_DLT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FRAME   = 2'd0,
    MODE_RENDER  = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RING,
    ST_DIV,
    ST_COMMIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic ring_upd;
    logic div_step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       gated;
    logic       smooth_en;
    logic       div_last;
    logic       out_free;
  } status_t;

endpackage

@@ rtl/frame_pacer_smoothed_delta.sv @@
// Top level of the frame pacer with smoothed frame delta.
//
// Input channel: now_us_i (48-bit time in us) and mode_i (frame update,
// mark rendered, restart) move as one beat on in_valid_i / in_stall_o.
// Output channel: one result beat per input beat on out_valid_o /
// out_stall_i, carrying the frame statistics after that item.
// Configuration: write cfg_wdata_i into register cfg_idx_i while cfg_we_i
// is high; only while the block is idle. Unknown indexes are dropped.
// Sequencing: a beat is taken only in the idle state, so one item is in flight
// at a time. A smoothed frame update steps through evaluate, ring update,
// one quotient bit a cycle over the 28-bit running sum, commit and result
// load. A raw frame update skips the ring update and the divider; mark,
// restart, gated or ignored items go from evaluate straight to result load.
// The divider is the longest step for smoothed frames.
// The result register parts the two sides: the next beat is taken while a
// result still waits; a stalled receiver holds the result steady and the
// block parks its next result until the register frees.
// Reset: registers go to their default values, statistics clear, the ring
// empties; no clearing pass is needed and beats are taken at once.
module frame_pacer_smoothed_delta (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fpsd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fpsd_pkg::DELTA_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fpsd_pkg::TIME_W-1:0]         now_us_i,
  input  logic [1:0]                          mode_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                frame_advanced_o,
  output logic [fpsd_pkg::DELTA_W-1:0]        delta_us_o,
  output logic [fpsd_pkg::TIME_W-1:0]         elapsed_us_o,
  output logic [fpsd_pkg::COUNT_W-1:0]        frames_done_o,
  output logic [fpsd_pkg::DELTA_W-1:0]        min_delta_us_o,
  output logic [fpsd_pkg::DELTA_W-1:0]        max_delta_us_seen_o,
  output logic [fpsd_pkg::DELTA_W-1:0]        wait_us_o
);

  fpsd_pkg::cmd_t    cmd;
  fpsd_pkg::status_t status;

  // Sequencer: takes beats, steps through evaluate, ring, divide, commit, result load.
  fpsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: configuration, pacer state, ring memory, divider, result.
  fpsd_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .now_us_i            (now_us_i),
    .mode_i              (mode_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .frame_advanced_o    (frame_advanced_o),
    .delta_us_o          (delta_us_o),
    .elapsed_us_o        (elapsed_us_o),
    .frames_done_o       (frames_done_o),
    .min_delta_us_o      (min_delta_us_o),
    .max_delta_us_seen_o (max_delta_us_seen_o),
    .wait_us_o           (wait_us_o),
    .cmd_i               (cmd),
    .status_o            (status)
  );

endmodule

@@ rtl/fpsd_ctrl.sv @@
// Sequencing state machine of the frame pacer.
`include "assert_macros.svh"

module fpsd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fpsd_pkg::status_t  status_i,
  output fpsd_pkg::cmd_t     cmd_o
);

  fpsd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      fpsd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = fpsd_pkg::ST_EVAL;
        end
      end
      fpsd_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.mode == fpsd_pkg::MODE_FRAME && !status_i.gated) begin
          state_d = status_i.smooth_en ? fpsd_pkg::ST_RING : fpsd_pkg::ST_COMMIT;
        end else begin
          state_d = fpsd_pkg::ST_OUT;
        end
      end
      fpsd_pkg::ST_RING: begin
        cmd_o.ring_upd = 1'b1;
        state_d        = fpsd_pkg::ST_DIV;
      end
      fpsd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = fpsd_pkg::ST_COMMIT;
        end
      end
      fpsd_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = fpsd_pkg::ST_OUT;
      end
      fpsd_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = fpsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpsd_pkg::ST_IDLE;
      end
    endcase
  end

  // An accepted beat always moves straight on to evaluation.
  `FPSD_ASSERT(a_capture_to_eval, clk_i, rst_ni,
    (state_q == fpsd_pkg::ST_IDLE && in_valid_i) |=> (state_q == fpsd_pkg::ST_EVAL))
  // A gated frame update never reaches the commit step.
  `FPSD_ASSERT(a_gated_skips_commit, clk_i, rst_ni,
    (state_q == fpsd_pkg::ST_EVAL && status_i.gated &&
     status_i.mode == fpsd_pkg::MODE_FRAME) |=> (state_q == fpsd_pkg::ST_OUT))
  // The ring update is always followed by the divider.
  `FPSD_ASSERT(a_ring_then_div, clk_i, rst_ni,
    (state_q == fpsd_pkg::ST_RING) |=> (state_q == fpsd_pkg::ST_DIV))
  // Never load a result over one still waiting for the receiver.
  `FPSD_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    cmd_o.load_out && !status_i.out_free)

endmodule

@@ rtl/fpsd_dp.sv @@
// Datapath of the frame pacer: registers, statistics, ring, divider, result.
module fpsd_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fpsd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fpsd_pkg::DELTA_W-1:0]        cfg_wdata_i,
  input  logic [fpsd_pkg::TIME_W-1:0]         now_us_i,
  input  logic [1:0]                          mode_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                frame_advanced_o,
  output logic [fpsd_pkg::DELTA_W-1:0]        delta_us_o,
  output logic [fpsd_pkg::TIME_W-1:0]         elapsed_us_o,
  output logic [fpsd_pkg::COUNT_W-1:0]        frames_done_o,
  output logic [fpsd_pkg::DELTA_W-1:0]        min_delta_us_o,
  output logic [fpsd_pkg::DELTA_W-1:0]        max_delta_us_seen_o,
  output logic [fpsd_pkg::DELTA_W-1:0]        wait_us_o,
  input  fpsd_pkg::cmd_t                      cmd_i,
  output fpsd_pkg::status_t                   status_o
);

  localparam int TW = fpsd_pkg::TIME_W;
  localparam int DW = fpsd_pkg::DELTA_W;
  localparam int SW = fpsd_pkg::SUM_W;
  localparam int AW = fpsd_pkg::RING_AW;
  localparam int CW = fpsd_pkg::CNT_W;
  localparam int KW = fpsd_pkg::DCNT_W;

  // configuration
  logic          limit_en_q, smooth_en_q;
  logic [DW-1:0] target_q, max_clamp_q, default_q;

  // captured beat and per-item working values
  logic [TW-1:0] now_q;
  logic [1:0]    mode_q;
  logic [DW-1:0] raw_q, wait_q;
  logic          adv_q;

  // pacer state
  logic [TW-1:0]                 last_frame_q, last_render_q, elapsed_q;
  logic [DW-1:0]                 cur_delta_q, min_q, max_q;
  logic [fpsd_pkg::COUNT_W-1:0]  frames_q;
  logic [AW-1:0]                 ptr_q;
  logic                          full_q;
  logic [SW-1:0]                 sum_q;

  // ring memory
  logic [DW-1:0] ring_mem [fpsd_pkg::SMOOTH_DEPTH];
  logic [DW-1:0] ring_rd_q;

  // divider
  logic [CW:0]   rem_q;
  logic [SW-1:0] quo_q;
  logic [CW-1:0] den_q;
  logic [KW-1:0] dcnt_q;

  // output register
  logic          out_valid_q;
  logic          adv_out_q;
  logic [DW-1:0] delta_out_q, min_out_q, max_out_q, wait_out_q;
  logic [TW-1:0] elapsed_out_q;
  logic [fpsd_pkg::COUNT_W-1:0] frames_out_q;

  // gate and interval evaluation
  logic          render_ok, frame_ok, gated;
  logic [TW-1:0] since, diff;
  logic [DW-1:0] wait_val, raw_val;

  assign render_ok = (now_q >= last_render_q);
  assign since     = now_q - last_render_q;
  assign gated     = limit_en_q && (target_q != '0) &&
                     (!render_ok || (since < {{(TW-DW){1'b0}}, target_q}));
  assign wait_val  = target_q - (render_ok ? since[DW-1:0] : '0);

  assign frame_ok  = (now_q >= last_frame_q);
  assign diff      = now_q - last_frame_q;
  always_comb begin
    if (!frame_ok) begin
      raw_val = '0;
    end else if (diff > {{(TW-DW){1'b0}}, max_clamp_q}) begin
      raw_val = max_clamp_q;
    end else begin
      raw_val = diff[DW-1:0];
    end
  end

  // ring update values
  logic [AW-1:0] ptr_nxt;
  logic          full_nxt;
  logic [SW-1:0] sum_nxt;
  logic [CW-1:0] count_nxt;

  assign ptr_nxt   = (ptr_q == AW'(fpsd_pkg::SMOOTH_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign full_nxt  = full_q || (ptr_nxt == '0);
  assign sum_nxt   = sum_q - (full_q ? SW'(ring_rd_q) : '0) + SW'(raw_q);
  assign count_nxt = full_nxt ? CW'(fpsd_pkg::SMOOTH_DEPTH) : CW'(ptr_nxt);

  // one restoring division step
  logic [CW:0]   shifted;
  logic [CW+1:0] trial;
  assign shifted = {rem_q[CW-1:0], quo_q[SW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  // commit values
  logic [DW-1:0] d_val;
  logic [TW:0]   elapsed_sum;
  assign d_val       = smooth_en_q ? quo_q[DW-1:0] : raw_q;
  assign elapsed_sum = {1'b0, elapsed_q} + (TW+1)'(d_val);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.mode      = mode_q;
  assign status_o.gated     = gated;
  assign status_o.smooth_en = smooth_en_q;
  assign status_o.div_last  = (dcnt_q == KW'(SW - 1));
  assign status_o.out_free  = out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_en_q  <= 1'b0;
      smooth_en_q <= 1'b1;
      target_q    <= '0;
      max_clamp_q <= fpsd_pkg::MAX_DELTA_RST;
      default_q   <= fpsd_pkg::DEFAULT_DELTA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fpsd_pkg::CFG_LIMIT_EN:    limit_en_q  <= cfg_wdata_i[0];
        fpsd_pkg::CFG_SMOOTH_EN:   smooth_en_q <= cfg_wdata_i[0];
        fpsd_pkg::CFG_TARGET:      target_q    <= cfg_wdata_i;
        fpsd_pkg::CFG_MAX_DELTA:   max_clamp_q <= cfg_wdata_i;
        fpsd_pkg::CFG_DEFAULT_DLT: default_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // capture beat; working values need no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q  <= now_us_i;
      mode_q <= mode_i;
    end
    if (cmd_i.eval) begin
      raw_q  <= raw_val;
      wait_q <= (mode_q == fpsd_pkg::MODE_FRAME && gated) ? wait_val : '0;
    end
  end

  // pacer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_frame_q  <= '0;
      last_render_q <= '0;
      cur_delta_q   <= fpsd_pkg::DEFAULT_DELTA_RST;
      elapsed_q     <= '0;
      frames_q      <= '0;
      min_q         <= '1;
      max_q         <= '0;
      ptr_q         <= '0;
      full_q        <= 1'b0;
      sum_q         <= '0;
      adv_q         <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        adv_q <= 1'b0;
        case (mode_q)
          fpsd_pkg::MODE_RENDER: begin
            last_render_q <= now_q;
          end
          fpsd_pkg::MODE_RESTART: begin
            last_frame_q  <= now_q;
            last_render_q <= now_q;
            cur_delta_q   <= default_q;
            elapsed_q     <= '0;
            frames_q      <= '0;
            min_q         <= '1;
            max_q         <= '0;
            ptr_q         <= '0;
            full_q        <= 1'b0;
            sum_q         <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.ring_upd) begin
        ptr_q  <= ptr_nxt;
        full_q <= full_nxt;
        sum_q  <= sum_nxt;
      end
      if (cmd_i.commit) begin
        adv_q        <= 1'b1;
        cur_delta_q  <= d_val;
        last_frame_q <= now_q;
        elapsed_q    <= elapsed_sum[TW] ? '1 : elapsed_sum[TW-1:0];
        frames_q     <= frames_q + 1'b1;
        if (d_val < min_q) begin
          min_q <= d_val;
        end
        if (d_val > max_q) begin
          max_q <= d_val;
        end
      end
    end
  end

  // ring memory: read the slot about to be replaced, then overwrite it
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      ring_rd_q <= ring_mem[ptr_q];
    end
    if (cmd_i.ring_upd) begin
      ring_mem[ptr_q] <= raw_q;
    end
  end

  // sequential divider: one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_upd) begin
      quo_q  <= sum_nxt;
      rem_q  <= '0;
      den_q  <= count_nxt;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[CW+1]) begin
        rem_q <= trial[CW:0];
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      adv_out_q     <= adv_q;
      delta_out_q   <= cur_delta_q;
      elapsed_out_q <= elapsed_q;
      frames_out_q  <= frames_q;
      min_out_q     <= min_q;
      max_out_q     <= max_q;
      wait_out_q    <= wait_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign frame_advanced_o    = adv_out_q;
  assign delta_us_o          = delta_out_q;
  assign elapsed_us_o        = elapsed_out_q;
  assign frames_done_o       = frames_out_q;
  assign min_delta_us_o      = min_out_q;
  assign max_delta_us_seen_o = max_out_q;
  assign wait_us_o           = wait_out_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the frame pacer with smoothed frame delta.
module testbench;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 3;
  localparam int ITEMS_TOTAL    = 1900;
  localparam int RANDOM_PHASES  = 9;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int IDLE_PCT       = 26;

  // Mode three is not decoded by the block; it must leave the state alone.
  localparam logic [1:0]                     MODE_IGNORED = 2'd3;
  localparam logic [fpsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [fpsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [fpsd_pkg::TIME_W-1:0]    TIME_MAX     = '1;
  localparam logic [fpsd_pkg::DELTA_W-1:0]   DELTA_MAX    = '1;

  typedef struct packed {
    logic                         advanced;
    logic [fpsd_pkg::DELTA_W-1:0] delta;
    logic [fpsd_pkg::TIME_W-1:0]  elapsed;
    logic [fpsd_pkg::COUNT_W-1:0] frames;
    logic [fpsd_pkg::DELTA_W-1:0] min_d;
    logic [fpsd_pkg::DELTA_W-1:0] max_d;
    logic [fpsd_pkg::DELTA_W-1:0] wait_t;
  } pacer_status_t;

  // Frame statistics predictor plus the queue of statuses still owed.
  class pacer_scoreboard;
    bit                            limit_en;
    bit                            smooth_en;
    logic [fpsd_pkg::DELTA_W-1:0]  target;
    logic [fpsd_pkg::DELTA_W-1:0]  max_clamp;
    logic [fpsd_pkg::DELTA_W-1:0]  default_delta;

    logic [fpsd_pkg::TIME_W-1:0]   last_frame;
    logic [fpsd_pkg::TIME_W-1:0]   last_render;
    logic [fpsd_pkg::TIME_W-1:0]   elapsed;
    logic [fpsd_pkg::DELTA_W-1:0]  cur_delta;
    logic [fpsd_pkg::DELTA_W-1:0]  min_d;
    logic [fpsd_pkg::DELTA_W-1:0]  max_d;
    logic [fpsd_pkg::COUNT_W-1:0]  frame_cnt;
    logic [fpsd_pkg::DELTA_W-1:0]  ring [fpsd_pkg::SMOOTH_DEPTH];
    int                            ring_ptr;
    bit                            ring_full;
    longint unsigned               ring_sum;

    pacer_status_t       owed_q[$];
    int                  errors;
    int                  checked;
    int                  frames_taken;
    int                  gated_cnt;
    int                  restarts;

    function new();
      limit_en      = 1'b0;
      smooth_en     = 1'b1;
      target        = '0;
      max_clamp     = fpsd_pkg::MAX_DELTA_RST;
      default_delta = fpsd_pkg::DEFAULT_DELTA_RST;
      restart('0);
    endfunction

    function void restart(logic [fpsd_pkg::TIME_W-1:0] t);
      last_frame  = t;
      last_render = t;
      cur_delta   = default_delta;
      elapsed     = '0;
      frame_cnt   = '0;
      min_d       = DELTA_MAX;
      max_d       = '0;
      ring_ptr    = 0;
      ring_full   = 1'b0;
      ring_sum    = 0;
    endfunction

    function void write_reg(logic [fpsd_pkg::CFG_IDX_W-1:0] idx,
                            logic [fpsd_pkg::DELTA_W-1:0] val);
      case (idx)
        fpsd_pkg::CFG_LIMIT_EN:    limit_en = val[0];
        fpsd_pkg::CFG_SMOOTH_EN:   smooth_en = val[0];
        fpsd_pkg::CFG_TARGET:      target = val;
        fpsd_pkg::CFG_MAX_DELTA:   max_clamp = val;
        fpsd_pkg::CFG_DEFAULT_DLT: default_delta = val;
        default: ;
      endcase
    endfunction

    function logic [fpsd_pkg::TIME_W-1:0] span(logic [fpsd_pkg::TIME_W-1:0] from,
                                               logic [fpsd_pkg::TIME_W-1:0] upto);
      return (upto >= from) ? upto - from : '0;
    endfunction

    // Push the clamped interval into the ring and return the truncated mean.
    function logic [fpsd_pkg::DELTA_W-1:0] average(logic [fpsd_pkg::DELTA_W-1:0] raw);
      longint unsigned fill;
      if (ring_full) ring_sum -= ring[ring_ptr];
      ring[ring_ptr] = raw;
      ring_sum += raw;
      ring_ptr = (ring_ptr + 1) % fpsd_pkg::SMOOTH_DEPTH;
      if (!ring_full && ring_ptr == 0) ring_full = 1'b1;
      fill = ring_full ? fpsd_pkg::SMOOTH_DEPTH : ring_ptr;
      if (fill == 0) fill = 1;
      return fpsd_pkg::DELTA_W'(ring_sum / fill);
    endfunction

    function void note_input(logic [fpsd_pkg::TIME_W-1:0] t, logic [1:0] m);
      pacer_status_t                e;
      logic [fpsd_pkg::TIME_W-1:0]  since;
      logic [fpsd_pkg::TIME_W-1:0]  raw;
      logic [fpsd_pkg::DELTA_W-1:0] d;
      logic [fpsd_pkg::TIME_W:0]    sum;
      bit                           gated;
      e.advanced = 1'b0;
      e.wait_t   = '0;
      gated      = 1'b0;
      case (m)
        fpsd_pkg::MODE_FRAME: begin
          if (limit_en && target != 0) begin
            since = span(last_render, t);
            if (since < fpsd_pkg::TIME_W'(target)) begin
              gated    = 1'b1;
              e.wait_t = target - since[fpsd_pkg::DELTA_W-1:0];
              gated_cnt++;
            end
          end
          if (!gated) begin
            raw = span(last_frame, t);
            if (raw > fpsd_pkg::TIME_W'(max_clamp)) raw = fpsd_pkg::TIME_W'(max_clamp);
            d = smooth_en ? average(raw[fpsd_pkg::DELTA_W-1:0])
                          : raw[fpsd_pkg::DELTA_W-1:0];
            cur_delta  = d;
            last_frame = t;
            sum = {1'b0, elapsed} + (fpsd_pkg::TIME_W+1)'(d);
            elapsed = sum[fpsd_pkg::TIME_W] ? TIME_MAX : sum[fpsd_pkg::TIME_W-1:0];
            frame_cnt++;
            if (d < min_d) min_d = d;
            if (d > max_d) max_d = d;
            e.advanced = 1'b1;
            frames_taken++;
          end
        end
        fpsd_pkg::MODE_RENDER:  last_render = t;
        fpsd_pkg::MODE_RESTART: begin
          restart(t);
          restarts++;
        end
        default: ;
      endcase
      e.delta   = cur_delta;
      e.elapsed = elapsed;
      e.frames  = frame_cnt;
      e.min_d   = min_d;
      e.max_d   = max_d;
      owed_q.push_back(e);
    endfunction

    function void compare(string name, longint unsigned want, longint unsigned got);
      if (want == got) return;
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%0h) got %0d (0x%0h)",
               $time, name, want, want, got, got);
    endfunction

    function void check_result(pacer_status_t got);
      pacer_status_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: status beat with nothing owed, expected none got 0x%0h",
                 $time, got);
        return;
      end
      e = owed_q.pop_front();
      checked++;
      compare("frame_advanced", e.advanced, got.advanced);
      compare("delta_us", e.delta, got.delta);
      compare("elapsed_us", e.elapsed, got.elapsed);
      compare("frames_done", e.frames, got.frames);
      compare("min_delta_us", e.min_d, got.min_d);
      compare("max_delta_us_seen", e.max_d, got.max_d);
      compare("wait_us", e.wait_t, got.wait_t);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [fpsd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [fpsd_pkg::DELTA_W-1:0]   cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [fpsd_pkg::TIME_W-1:0]    now_us_i;
  logic [1:0]                     mode_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic                           frame_advanced_o;
  logic [fpsd_pkg::DELTA_W-1:0]   delta_us_o;
  logic [fpsd_pkg::TIME_W-1:0]    elapsed_us_o;
  logic [fpsd_pkg::COUNT_W-1:0]   frames_done_o;
  logic [fpsd_pkg::DELTA_W-1:0]   min_delta_us_o;
  logic [fpsd_pkg::DELTA_W-1:0]   max_delta_us_seen_o;
  logic [fpsd_pkg::DELTA_W-1:0]   wait_us_o;

  pacer_scoreboard     sb = new();
  pacer_status_t       status_seen;

  // Knobs shared between the sender, the receiver and the sequence.
  int                  idle_pct = IDLE_PCT;
  int                  stall_pct = IDLE_PCT;
  int                  holdoff_left = 0;
  int                  cycle_count = 0;
  int                  items_sent = 0;
  int                  ignored_sent = 0;
  int                  reg_writes = 0;

  // Local view of the programmed period and clamp, used to pace timestamps.
  logic [fpsd_pkg::DELTA_W-1:0]  target_now = '0;
  logic [fpsd_pkg::DELTA_W-1:0]  clamp_now = fpsd_pkg::MAX_DELTA_RST;
  logic [fpsd_pkg::TIME_W-1:0]   clock_now = '0;

  always #CLK_HALF clk_i = ~clk_i;

  frame_pacer_smoothed_delta u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .now_us_i            (now_us_i),
    .mode_i              (mode_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .frame_advanced_o    (frame_advanced_o),
    .delta_us_o          (delta_us_o),
    .elapsed_us_o        (elapsed_us_o),
    .frames_done_o       (frames_done_o),
    .min_delta_us_o      (min_delta_us_o),
    .max_delta_us_seen_o (max_delta_us_seen_o),
    .wait_us_o           (wait_us_o)
  );

  // Receiver: check each status beat, then pick the stall for the next edge.
  // A requested hold-off is counted down here, once per rising edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        status_seen.advanced = frame_advanced_o;
        status_seen.delta    = delta_us_o;
        status_seen.elapsed  = elapsed_us_o;
        status_seen.frames   = frames_done_o;
        status_seen.min_d    = min_delta_us_o;
        status_seen.max_d    = max_delta_us_seen_o;
        status_seen.wait_t   = wait_us_o;
        sb.check_result(status_seen);
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: give up if the run overstays the cycle budget.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: timed out after %0d cycles, %0d statuses still owed",
             cycle_count, sb.pending());
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [fpsd_pkg::TIME_W-1:0] any_time();
    return fpsd_pkg::TIME_W'({$urandom, $urandom});
  endfunction

  // Offer one beat after a random gap and hold it until it is taken.
  // The caller is always just past a rising edge, so valid gets one update per step.
  task automatic send_beat(logic [fpsd_pkg::TIME_W-1:0] t, logic [1:0] m);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_us_i   <= t;
    mode_i     <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(t, m);
    if (m == MODE_IGNORED) ignored_sent++;
    else items_sent++;
  endtask

  // Drop valid and wait until every owed status has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Leave the write enable high; the caller lowers it after its last write.
  task automatic write_reg(logic [fpsd_pkg::CFG_IDX_W-1:0] idx,
                           logic [fpsd_pkg::DELTA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    reg_writes++;
  endtask

  task automatic configure(bit lim, bit smo, logic [fpsd_pkg::DELTA_W-1:0] tgt,
                           logic [fpsd_pkg::DELTA_W-1:0] clamp,
                           logic [fpsd_pkg::DELTA_W-1:0] dflt);
    write_reg(fpsd_pkg::CFG_LIMIT_EN, fpsd_pkg::DELTA_W'(lim));
    write_reg(fpsd_pkg::CFG_SMOOTH_EN, fpsd_pkg::DELTA_W'(smo));
    write_reg(fpsd_pkg::CFG_TARGET, tgt);
    write_reg(fpsd_pkg::CFG_MAX_DELTA, clamp);
    write_reg(fpsd_pkg::CFG_DEFAULT_DLT, dflt);
    cfg_we_i   <= 1'b0;
    target_now = tgt;
    clamp_now  = clamp;
    @(posedge clk_i);
  endtask

  // Mostly well-formed frame / render pairs spaced around the target period,
  // with a sprinkling of restarts, ignored modes, backward and wild timestamps.
  task automatic random_phase(int quota, bit do_holdoff, bit do_pause);
    int                          done;
    int                          base;
    bit                          mid_done;
    longint unsigned             step_hi;
    logic [fpsd_pkg::TIME_W-1:0] t;
    done     = 0;
    mid_done = 1'b0;
    clock_now = ($urandom_range(3) == 0)
                ? TIME_MAX - fpsd_pkg::TIME_W'($urandom_range(2000000))
                : any_time();
    send_beat(clock_now, fpsd_pkg::MODE_RESTART);
    base = items_sent;
    while (done < quota) begin
      if (!mid_done && done >= quota / 2) begin
        mid_done = 1'b1;
        if (do_holdoff && holdoff_left == 0) holdoff_left = HOLDOFF_CYCLES;
        if (do_pause) settle();
      end
      if (target_now != 0) step_hi = 2 * longint'(target_now);
      else if (clamp_now != 0) step_hi = longint'(clamp_now) + clamp_now / 4;
      else step_hi = 40000;
      if (step_hi < 16) step_hi = 16;
      case ($urandom_range(99)) inside
        [0:1]: begin
          clock_now = any_time();
          send_beat(clock_now, fpsd_pkg::MODE_RESTART);
        end
        [2:5]: begin
          case ($urandom_range(4))
            0: send_beat(any_time(), MODE_IGNORED);
            1: send_beat(clock_now - fpsd_pkg::TIME_W'($urandom_range(50000, 1)),
                         fpsd_pkg::MODE_FRAME);
            2: begin
              clock_now += fpsd_pkg::TIME_W'($urandom);
              send_beat(clock_now, fpsd_pkg::MODE_FRAME);
            end
            3: send_beat(any_time(), fpsd_pkg::MODE_RENDER);
            default: begin
              clock_now = any_time();
              send_beat(clock_now, fpsd_pkg::MODE_FRAME);
            end
          endcase
        end
        default: begin
          clock_now += fpsd_pkg::TIME_W'($urandom_range(32'(step_hi), 0));
          send_beat(clock_now, fpsd_pkg::MODE_FRAME);
          if ($urandom_range(99) < 70) begin
            t = clock_now + fpsd_pkg::TIME_W'($urandom_range(32'(step_hi / 8), 0));
            send_beat(t, fpsd_pkg::MODE_RENDER);
            clock_now = t;
          end
        end
      endcase
      done = items_sent - base;
    end
    settle();
  endtask

  initial begin
    int phase_quota;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= fpsd_pkg::CFG_LIMIT_EN;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    now_us_i    <= '0;
    mode_i      <= fpsd_pkg::MODE_FRAME;
    out_stall_i <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: zero interval, clamp, backward time, ignored mode,
    // restart at the top of the time range.
    send_beat('0, fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(5000), fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(123), MODE_IGNORED);
    send_beat(fpsd_pkg::TIME_W'(6000), fpsd_pkg::MODE_RENDER);
    send_beat(fpsd_pkg::TIME_W'(200000), fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(100), fpsd_pkg::MODE_FRAME);
    send_beat(TIME_MAX, fpsd_pkg::MODE_RESTART);
    send_beat(TIME_MAX, fpsd_pkg::MODE_FRAME);
    send_beat('0, fpsd_pkg::MODE_RESTART);
    settle();

    // Gating on, raw deltas; spare indexes must be dropped.
    write_reg(CFG_SPARE_LO, DELTA_MAX);
    write_reg(CFG_SPARE_HI, DELTA_MAX);
    configure(1'b1, 1'b0, fpsd_pkg::DELTA_W'(1000), fpsd_pkg::MAX_DELTA_RST,
              fpsd_pkg::DEFAULT_DELTA_RST);
    send_beat(fpsd_pkg::TIME_W'(10000), fpsd_pkg::MODE_RENDER);
    send_beat(fpsd_pkg::TIME_W'(10500), fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(9000), fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(11000), fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(11001), MODE_IGNORED);
    settle();

    // Gating on, smoothing off; target, clamp and default at their maximum.
    configure(1'b1, 1'b0, DELTA_MAX, DELTA_MAX, DELTA_MAX);
    send_beat('0, fpsd_pkg::MODE_RESTART);
    send_beat(fpsd_pkg::TIME_W'(1), fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(DELTA_MAX), fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(1) << 30, fpsd_pkg::MODE_RENDER);
    send_beat((fpsd_pkg::TIME_W'(1) << 30) + (fpsd_pkg::TIME_W'(1) << 25),
              fpsd_pkg::MODE_FRAME);
    settle();

    // Every register at zero, smoothing back on.
    configure(1'b0, 1'b1, '0, '0, '0);
    send_beat(fpsd_pkg::TIME_W'(1000), fpsd_pkg::MODE_RESTART);
    send_beat(fpsd_pkg::TIME_W'(5000), fpsd_pkg::MODE_FRAME);
    send_beat(fpsd_pkg::TIME_W'(6000), fpsd_pkg::MODE_FRAME);
    settle();

    phase_quota = ITEMS_TOTAL / RANDOM_PHASES;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(1'b1, 1'b1, fpsd_pkg::DEFAULT_DELTA_RST, fpsd_pkg::MAX_DELTA_RST,
                     fpsd_pkg::DEFAULT_DELTA_RST);
        1: configure(1'b1, 1'b0, DELTA_MAX, DELTA_MAX, DELTA_MAX);
        2: configure(1'b0, 1'b1, '0, '0, '0);
        default: configure(
          1'($urandom_range(1)), 1'($urandom_range(1)),
          ($urandom_range(5) == 0) ? '0 :
            ($urandom_range(4) == 0) ? DELTA_MAX
                                     : fpsd_pkg::DELTA_W'($urandom_range(50000, 100)),
          ($urandom_range(5) == 0) ? '0 :
            ($urandom_range(4) == 0) ? DELTA_MAX
                                     : fpsd_pkg::DELTA_W'($urandom_range(200000, 1)),
          fpsd_pkg::DELTA_W'($urandom));
      endcase
      // One phase runs with neither side idling at all.
      idle_pct  = (p == 4) ? 0 : IDLE_PCT;
      stall_pct = (p == 4) ? 0 : IDLE_PCT;
      random_phase(phase_quota, p == 0 || p == 6, p == 3);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: statuses left owed, expected 0 got %0d", $time, sb.pending());
    end
    $display("testbench: %0d items (%0d frames taken, %0d gated, %0d restarts) plus %0d ignored",
             items_sent, sb.frames_taken, sb.gated_cnt, sb.restarts, ignored_sent);
    $display("testbench: %0d statuses checked, %0d register writes, %0d mismatches",
             sb.checked, reg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/fpsd_pkg.sv
rtl/fpsd_ctrl.sv
rtl/fpsd_dp.sv
rtl/frame_pacer_smoothed_delta.sv
test/testbench.sv
